// ===== hdl/websocket_frame_deframer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the WebSocket deframer
// Shared concurrent assertion forms, all clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge out of reset.
`define WSD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("wsd assertion failed");

// Antecedent implies consequent in the same cycle.
`define WSD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("wsd implication failed");

// Antecedent implies consequent in the next cycle.
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("wsd sequence failed");

`else

`define WSD_ASSERT(lbl, cond)
`define WSD_ASSERT_IMPL(lbl, ante, cons)
`define WSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and codes shared by the WebSocket deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PONG  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_LEN64   = 3'd0;
    localparam logic [2:0] ERR_TOOLONG = 3'd1;
    localparam logic [2:0] ERR_FRAG    = 3'd2;
    localparam logic [2:0] ERR_UNMASK  = 3'd3;
    localparam logic [2:0] ERR_NOTOPEN = 3'd4;

    // Opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    // Length codes of the second header byte
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Register map
    localparam int unsigned  APB_ADDR_W      = 3;
    localparam int unsigned  APB_DATA_W      = 32;
    localparam logic         REG_MAX_PAYLOAD = 1'b0;
    localparam logic         REG_LINK_OPEN   = 1'b1;
    localparam logic [15:0]  MAX_PAYLOAD_RST = 16'd4096;

    typedef struct packed {
        logic [15:0] max_payload;
        logic        link_open;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       is_binary;
        logic       last;
        logic [2:0] error_code;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/wsd_cfg.sv =====
// ----------------------------------------------------------------------------
// wsd_cfg
// APB register file: payload limit and link-open switch.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_cfg import wsd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [15:0] r_max_payload;
    logic        r_link_open;
    logic        w_wr;
    logic        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_link_open   <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_PAYLOAD: r_max_payload <= pwdata[15:0];
                REG_LINK_OPEN:   r_link_open   <= pwdata[0];
                default:         r_link_open   <= r_link_open;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MAX_PAYLOAD: prdata[15:0] = r_max_payload;
            REG_LINK_OPEN:   prdata[0]    = r_link_open;
            default:         prdata       = '0;
        endcase
    end

    assign o_cfg.max_payload = r_max_payload;
    assign o_cfg.link_open   = r_link_open;

endmodule

`default_nettype wire

// ===== hdl/wsd_parse.sv =====
// ----------------------------------------------------------------------------
// wsd_parse
// Frame header state machine and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_deframer_core_assert.svh"

module wsd_parse import wsd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    typedef enum logic [3:0] {
        PH_HDR0, PH_HDR1, PH_EXT_HI, PH_EXT_LO,
        PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3,
        PH_PAYLOAD, PH_CLOSED, PH_ERR
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [2:0]  r_err,       n_err;
    logic [3:0]  r_opcode,    n_opcode;
    logic        r_fin,       n_fin;
    logic        r_mask_bit,  n_mask_bit;
    logic [7:0]  r_len_hi,    n_len_hi;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_mask_key,  n_mask_key;
    logic [1:0]  r_mask_pos,  n_mask_pos;

    logic        w_len_known;
    logic        w_frame_end;
    logic [15:0] w_len;
    logic        w_mask;
    logic [7:0]  w_key;
    logic        w_is_last;

    // Length and mask bit come straight from the byte on a short header
    assign w_len  = (r_phase == PH_HDR1) ? {9'd0, i_byte[6:0]} : {r_len_hi, i_byte};
    assign w_mask = (r_phase == PH_HDR1) ? i_byte[7] : r_mask_bit;
    assign w_key  = r_mask_key[{~r_mask_pos, 3'b111} -: 8];
    assign w_is_last = (r_bytes_left <= 16'd1);

    always_comb begin
        n_phase      = r_phase;
        n_err        = r_err;
        n_opcode     = r_opcode;
        n_fin        = r_fin;
        n_mask_bit   = r_mask_bit;
        n_len_hi     = r_len_hi;
        n_bytes_left = r_bytes_left;
        n_mask_key   = r_mask_key;
        n_mask_pos   = r_mask_pos;
        w_len_known  = 1'b0;
        w_frame_end  = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (!i_cfg.link_open) begin
            // Reject without touching the state
            o_res_valid      = 1'b1;
            o_res.kind       = KIND_ERROR;
            o_res.error_code = ERR_NOTOPEN;
        end else begin
            unique case (r_phase)
                PH_ERR: begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = r_err;
                end
                PH_HDR0: begin
                    n_opcode = i_byte[3:0];
                    n_fin    = i_byte[7];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_mask_bit = i_byte[7];
                    if (i_byte[6:0] == LEN_CODE_EXT64) begin
                        n_phase          = PH_ERR;
                        n_err            = ERR_LEN64;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_LEN64;
                    end else if (i_byte[6:0] == LEN_CODE_EXT16) begin
                        n_len_hi = 8'd0;
                        n_phase  = PH_EXT_HI;
                    end else begin
                        w_len_known = 1'b1;
                    end
                end
                PH_EXT_HI: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_EXT_LO;
                end
                PH_EXT_LO: w_len_known = 1'b1;
                PH_MASK0: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_phase    = PH_MASK1;
                end
                PH_MASK1: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_phase    = PH_MASK2;
                end
                PH_MASK2: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_phase    = PH_MASK3;
                end
                PH_MASK3: begin
                    n_mask_key = {r_mask_key[23:0], i_byte};
                    n_mask_pos = 2'd0;
                    if (r_bytes_left == 16'd0) begin
                        w_frame_end = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_pos   = r_mask_pos + 2'd1;
                    n_bytes_left = r_bytes_left - 16'd1;
                    if (r_opcode == OP_TEXT || r_opcode == OP_BINARY) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_DATA;
                        o_res.data      = i_byte ^ w_key;
                        o_res.is_binary = (r_opcode == OP_BINARY);
                        o_res.last      = w_is_last;
                        if (w_is_last) begin
                            n_phase = PH_HDR0;
                        end
                    end else if (w_is_last) begin
                        w_frame_end = 1'b1;
                    end
                end
                PH_CLOSED: n_phase = PH_CLOSED;
                default:   n_phase = r_phase;
            endcase

            // Header checks in fixed order once the length is in hand
            if (w_len_known) begin
                priority if (w_len > i_cfg.max_payload) begin
                    n_err = ERR_TOOLONG;
                end else if (!r_fin) begin
                    n_err = ERR_FRAG;
                end else if (!w_mask) begin
                    n_err = ERR_UNMASK;
                end else begin
                    n_err = r_err;
                end
                if (w_len > i_cfg.max_payload || !r_fin || !w_mask) begin
                    n_phase          = PH_ERR;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = n_err;
                end else begin
                    n_bytes_left = w_len;
                    n_phase      = PH_MASK0;
                end
            end

            if (w_frame_end) begin
                n_phase = PH_HDR0;
                if (r_opcode == OP_PING) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PONG;
                end else if (r_opcode == OP_CLOSE) begin
                    n_phase     = PH_CLOSED;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_CLOSE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR0;
            r_err        <= ERR_LEN64;
            r_opcode     <= 4'd0;
            r_fin        <= 1'b0;
            r_mask_bit   <= 1'b0;
            r_len_hi     <= 8'd0;
            r_bytes_left <= 16'd0;
            r_mask_key   <= 32'd0;
            r_mask_pos   <= 2'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_err        <= n_err;
            r_opcode     <= n_opcode;
            r_fin        <= n_fin;
            r_mask_bit   <= n_mask_bit;
            r_len_hi     <= n_len_hi;
            r_bytes_left <= n_bytes_left;
            r_mask_key   <= n_mask_key;
            r_mask_pos   <= n_mask_pos;
        end
    end

    // Close halts for good; errors stick with their code
    `WSD_ASSERT_NEXT(a_closed_sticky, r_phase == PH_CLOSED, r_phase == PH_CLOSED)
    `WSD_ASSERT_NEXT(a_err_sticky, r_phase == PH_ERR, r_phase == PH_ERR && $stable(r_err))
    `WSD_ASSERT_IMPL(a_payload_nonzero, r_phase == PH_PAYLOAD, r_bytes_left != 16'd0)
    `WSD_ASSERT_IMPL(a_err_code_range, r_phase == PH_ERR, r_err != ERR_NOTOPEN)

endmodule

`default_nettype wire

// ===== hdl/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// WebSocket client-to-server receive deframer with APB configuration.
// ----------------------------------------------------------------------------
// Bytes enter on the rx channel, one per transaction, and are parsed through
// the frame header (opcode, mask bit, 7-bit or 16-bit length, 4-byte mask key)
// with text and binary payload unmasked and returned one result per byte.
// Pings produce a pong request after the last byte, a close is reported and
// halts the block, and header errors stick until reset. The block takes one
// byte every cycle while results are taken: a byte is held in the input
// register, passes the header state machine and unmask XOR, and lands in the
// result register, and a stalled result holds one more byte in the input
// register. Configuration writes must be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_core import wsd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // Received bytes
    input  wire logic                  i_rx_valid,
    output logic                       o_rx_ready,
    input  wire logic [7:0]            i_rx_byte,
    // Results
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic      [1:0]            o_kind,
    output logic      [7:0]            o_data,
    output logic                       o_is_binary,
    output logic                       o_last,
    output logic      [2:0]            o_error_code
);

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_res_valid;
    logic    w_step;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    wsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance the held byte when the result slot is free or draining
    assign w_step     = r_in_valid & (~r_out_valid | i_res_ready);
    assign o_rx_ready = ~r_in_valid | w_step;

    wsd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= w_res_valid;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_data       = r_out.data;
    assign o_is_binary  = r_out.is_binary;
    assign o_last       = r_out.last;
    assign o_error_code = r_out.error_code;

endmodule

`default_nettype wire
